/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define MMA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define MMA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/mma_pkg.sv */
// Shared widths, request codes and item types of the moving average block.
package mma_pkg;

    localparam int REQ_W        = 2;
    localparam int CH_W         = 6;
    localparam int SAMPLE_W     = 16;
    localparam int MEAN_W       = 24;
    localparam int FILL_W       = 5;
    localparam int SUM_W        = 20;
    localparam int FRAC_W       = 8;
    localparam int NUM_W        = SUM_W + FRAC_W;

    localparam int DEF_CHANNELS = 64;
    localparam int DEF_DEPTH    = 16;
    localparam int WIN_RESET    = 16;
    localparam int FQ_DEPTH     = 4;

    localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_READ,
        OP_READ_ZERO,
        OP_CLEAR,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op                        op;
        logic [CH_W-1:0]            ch;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       fend;
    } t_item;

    typedef struct packed {
        logic signed [MEAN_W-1:0] mean;
        logic [FILL_W-1:0]        fill;
        logic                     is_read;
    } t_result;

endpackage

/* rtl/mma_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module mma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                    i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                    o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/mma_front.sv */
// Request queue: decodes incoming requests and buffers them for the execution side.
module mma_front #(
    parameter int CHANNELS = mma_pkg::DEF_CHANNELS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    output logic                                o_full,
    input  logic [mma_pkg::REQ_W-1:0]           i_req_type,
    input  logic [mma_pkg::CH_W-1:0]            i_channel,
    input  logic signed [mma_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                i_frame_end,
    output mma_pkg::t_item                      o_item,
    output logic                                o_valid,
    input  logic                                i_pop
);

    import mma_pkg::*;

    localparam int QAW   = $clog2(FQ_DEPTH);
    localparam int CNT_W = $clog2(FQ_DEPTH + 1);

    t_item            r_q [FQ_DEPTH];
    logic [QAW-1:0]   r_wp, n_wp;
    logic [QAW-1:0]   r_rp, n_rp;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_item            item_c;
    logic             ch_ok;
    logic             push_ok;
    logic             pop_ok;

    // Out-of-range channels are resolved here so the back end never checks them.
    always_comb begin
        ch_ok         = (32'(i_channel) < CHANNELS);
        item_c.ch     = i_channel;
        item_c.sample = i_sample;
        item_c.fend   = i_frame_end;
        case (i_req_type)
            REQ_ADD:   item_c.op = ch_ok ? OP_ADD : OP_NOP;
            REQ_READ:  item_c.op = ch_ok ? OP_READ : OP_READ_ZERO;
            REQ_CLEAR: item_c.op = OP_CLEAR;
            default:   item_c.op = OP_NOP;
        endcase
    end

    assign push_ok = i_push & ~o_full;
    assign pop_ok  = i_pop & o_valid;

    always_comb begin
        n_wp  = push_ok ? r_wp + 1'b1 : r_wp;
        n_rp  = pop_ok ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt;
        case ({push_ok, pop_ok})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wp] <= item_c;
        end
    end

    assign o_full  = (r_cnt == CNT_W'(FQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_q[r_rp];

endmodule

/* rtl/mma_div.sv */
// Restoring divider for the mean: |sum| * 256 over the fill count, one bit per cycle.
module mma_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [mma_pkg::SUM_W-1:0]  i_sum,
    input  logic [mma_pkg::FILL_W-1:0]        i_divisor,
    output logic                              o_done,
    output logic signed [mma_pkg::MEAN_W-1:0] o_quot
);

    import mma_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam logic [NUM_W-1:0] POS_LIM = NUM_W'((2 ** (MEAN_W - 1)) - 1);
    localparam logic [NUM_W-1:0] NEG_LIM = NUM_W'(2 ** (MEAN_W - 1));

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [NUM_W-1:0]  r_num, n_num;
    logic [FILL_W-1:0] r_rem, n_rem;
    logic [FILL_W-1:0] r_den, n_den;
    logic              r_neg, n_neg;
    logic [SUM_W-1:0]  mag;
    logic [FILL_W:0]   rem_sh;
    logic [FILL_W:0]   rem_sub;
    logic              ge;

    assign mag     = i_sum[SUM_W-1] ? (~i_sum + 1'b1) : i_sum;
    assign rem_sh  = {r_rem, r_num[NUM_W-1]};
    assign ge      = (rem_sh >= {1'b0, r_den});
    assign rem_sub = ge ? (rem_sh - {1'b0, r_den}) : rem_sh;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_rem  = r_rem;
        n_den  = r_den;
        n_neg  = r_neg;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(NUM_W);
            n_num  = {mag, {FRAC_W{1'b0}}};
            n_rem  = '0;
            n_den  = i_divisor;
            n_neg  = i_sum[SUM_W-1];
        end else if (r_busy) begin
            // The remainder stays below the divisor, so it fits the divisor width.
            n_num = {r_num[NUM_W-2:0], ge};
            n_rem = rem_sub[FILL_W-1:0];
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_num <= n_num;
        r_rem <= n_rem;
        r_den <= n_den;
        r_neg <= n_neg;
    end

    // The quotient magnitude can exceed the result range, so it saturates here.
    always_comb begin
        if (r_neg) begin
            o_quot = (r_num > NEG_LIM) ? NEG_LIM[MEAN_W-1:0] : (~r_num[MEAN_W-1:0] + 1'b1);
        end else begin
            o_quot = (r_num > POS_LIM) ? POS_LIM[MEAN_W-1:0] : r_num[MEAN_W-1:0];
        end
    end

    assign o_done = r_done;

endmodule

/* rtl/mma_back.sv */
// Execution side: window store, running sums, frame counters and the result register.
module mma_back #(
    parameter int CHANNELS = mma_pkg::DEF_CHANNELS,
    parameter int DEPTH    = mma_pkg::DEF_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mma_pkg::t_item               i_item,
    input  logic                         i_item_valid,
    output logic                         o_item_pop,
    input  logic                         i_cfg_valid,
    input  logic [mma_pkg::FILL_W-1:0]   i_cfg_data,
    output mma_pkg::t_result             o_out,
    output logic                         o_out_valid,
    input  logic                         i_out_pop
);

    import mma_pkg::*;

    localparam int NCH      = (CHANNELS > (2 ** CH_W)) ? (2 ** CH_W) : CHANNELS;
    localparam int CH_AW    = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int SLOT_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ST_DEPTH = NCH * DEPTH;
    localparam int ST_AW    = (ST_DEPTH > 1) ? $clog2(ST_DEPTH) : 1;
    localparam int WIN_RST  = (WIN_RESET > DEPTH) ? DEPTH : WIN_RESET;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV
    } t_state;

    t_state             r_state, n_state;
    t_item              r_item, n_item;
    logic [ST_AW-1:0]   r_st_addr, n_st_addr;
    logic [FILL_W-1:0]  r_win, n_win;
    logic [SLOT_W-1:0]  r_slot, n_slot;
    logic [FILL_W-1:0]  r_fill, n_fill;
    logic [NCH-1:0]     r_sum_vld, n_sum_vld;
    t_result            r_out, n_out;
    logic               r_out_vld, n_out_vld;

    logic               take;
    logic [ST_AW-1:0]   st_raddr;
    logic [CH_AW-1:0]   cur_idx;
    logic               add_we;
    logic [SAMPLE_W-1:0] st_q;
    logic [SUM_W-1:0]   sums_q;
    logic [SUM_W-1:0]   cur_sum;
    logic [SUM_W-1:0]   old_ext;
    logic [SUM_W-1:0]   new_ext;
    logic [SUM_W-1:0]   new_sum;
    logic               full_win;
    logic               slot_wrap;
    logic               div_start;
    logic               div_done;
    logic signed [MEAN_W-1:0] div_quot;
    logic [FILL_W-1:0]  cfg_win;
    t_result            res_c;

    assign take       = (r_state == S_IDLE) && i_item_valid && !r_out_vld;
    assign o_item_pop = take;
    assign st_raddr   = ST_AW'(32'(i_item.ch) * DEPTH + 32'(r_slot));
    assign cur_idx    = r_item.ch[CH_AW-1:0];
    assign add_we     = (r_state == S_EXEC) && (r_item.op == OP_ADD);

    mma_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (ST_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (add_we),
        .i_waddr (r_st_addr),
        .i_wdata (r_item.sample),
        .i_raddr (st_raddr),
        .o_rdata (st_q)
    );

    mma_ram #(
        .WIDTH (SUM_W),
        .DEPTH (NCH)
    ) u_sums (
        .i_clk   (i_clk),
        .i_we    (add_we),
        .i_waddr (cur_idx),
        .i_wdata (new_sum),
        .i_raddr (i_item.ch[CH_AW-1:0]),
        .o_rdata (sums_q)
    );

    // A sum whose valid bit is clear reads as zero; clearing only drops the valid bits.
    assign cur_sum   = r_sum_vld[cur_idx] ? sums_q : '0;
    assign full_win  = (r_fill >= r_win);
    assign old_ext   = full_win ? {{(SUM_W - SAMPLE_W){st_q[SAMPLE_W-1]}}, st_q} : '0;
    assign new_ext   = {{(SUM_W - SAMPLE_W){r_item.sample[SAMPLE_W-1]}}, r_item.sample};
    assign new_sum   = cur_sum - old_ext + new_ext;
    assign slot_wrap = ((32'(r_slot) + 1) >= 32'(r_win));
    assign div_start = (r_state == S_EXEC) && (r_item.op == OP_READ) && (r_fill != '0);

    mma_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_sum     (cur_sum),
        .i_divisor (r_fill),
        .o_done    (div_done),
        .o_quot    (div_quot)
    );

    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_win = FILL_W'(1);
        end else if (32'(i_cfg_data) > DEPTH) begin
            cfg_win = FILL_W'(DEPTH);
        end else begin
            cfg_win = i_cfg_data;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_item    = r_item;
        n_st_addr = r_st_addr;
        n_win     = r_win;
        n_slot    = r_slot;
        n_fill    = r_fill;
        n_sum_vld = r_sum_vld;
        n_out     = r_out;
        n_out_vld = r_out_vld & ~i_out_pop;
        res_c.mean    = '0;
        res_c.fill    = r_fill;
        res_c.is_read = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (take) begin
                    n_item    = i_item;
                    n_st_addr = st_raddr;
                    n_state   = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                case (r_item.op)
                    OP_ADD: begin
                        n_sum_vld[cur_idx] = 1'b1;
                        if (r_item.fend) begin
                            n_slot = slot_wrap ? '0 : r_slot + 1'b1;
                            n_fill = full_win ? r_fill : r_fill + 1'b1;
                        end
                        res_c.fill = n_fill;
                    end
                    OP_READ: begin
                        res_c.is_read = 1'b1;
                        if (r_fill != '0) begin
                            n_state = S_DIV;
                        end
                    end
                    OP_READ_ZERO: begin
                        res_c.is_read = 1'b1;
                    end
                    OP_CLEAR: begin
                        n_sum_vld  = '0;
                        n_slot     = '0;
                        n_fill     = '0;
                        res_c.fill = '0;
                    end
                    default: begin
                        res_c.fill = r_fill;
                    end
                endcase
                if (n_state == S_IDLE) begin
                    n_out     = res_c;
                    n_out_vld = 1'b1;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_out.mean    = div_quot;
                    n_out.fill    = r_fill;
                    n_out.is_read = 1'b1;
                    n_out_vld     = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A window length write also clears every window.
        if (i_cfg_valid) begin
            n_win     = cfg_win;
            n_sum_vld = '0;
            n_slot    = '0;
            n_fill    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_win     <= FILL_W'(WIN_RST);
            r_slot    <= '0;
            r_fill    <= '0;
            r_sum_vld <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_win     <= n_win;
            r_slot    <= n_slot;
            r_fill    <= n_fill;
            r_sum_vld <= n_sum_vld;
            r_out_vld <= n_out_vld;
        end
        r_item    <= n_item;
        r_st_addr <= n_st_addr;
        r_out     <= n_out;
    end

    assign o_out       = r_out;
    assign o_out_valid = r_out_vld;

endmodule

/* rtl/multichannel_moving_average.sv */
// Top level of the multichannel boxcar moving average block.
//
// Requests enter through a queue-style port: push with full. Each request is
// an add of one channel's sample (frame_end marks the last channel of a
// frame), a read of one channel's mean, or a clear of all windows. Every
// request yields exactly one result, which waits on the output ports while
// empty is low and leaves on pop. A four-entry request queue lets requests be
// pushed while a result is still waiting to be popped.
// The window length register is written through i_cfg_valid / i_cfg_data;
// the write also clears all windows and must be made while the block is idle.
// Requests other than a read of a filled window pass through the request
// queue, the registered store and sum reads and the update; their result is
// registered. A read of a filled window also waits on the restoring divider,
// which makes one quotient bit per cycle over 28 bits. The next request
// starts only after the result is popped, so a new request is not taken
// while the last result still waits. Synchronous reset empties the request
// queue and the result register, zeroes all running sums and the fill count,
// and sets the window length to 16. When the receiver does not pop, the
// result is held and the request queue fills, then full stays high.
module multichannel_moving_average #(
    parameter int CHANNELS = mma_pkg::DEF_CHANNELS,
    parameter int DEPTH    = mma_pkg::DEF_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [mma_pkg::REQ_W-1:0]           i_req_type,
    input  logic [mma_pkg::CH_W-1:0]            i_channel,
    input  logic signed [mma_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                i_frame_end,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [mma_pkg::MEAN_W-1:0]   o_mean,
    output logic [mma_pkg::FILL_W-1:0]          o_samples_in_window,
    output logic                                o_is_read_answer,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mma_pkg::FILL_W-1:0]          i_cfg_data
);

    import mma_pkg::*;

    t_item   item;
    logic    item_valid;
    logic    item_pop;
    t_result out;
    logic    out_valid;

    mma_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_req_type  (i_req_type),
        .i_channel   (i_channel),
        .i_sample    (i_sample),
        .i_frame_end (i_frame_end),
        .o_item      (item),
        .o_valid     (item_valid),
        .i_pop       (item_pop)
    );

    mma_back #(
        .CHANNELS (CHANNELS),
        .DEPTH    (DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item),
        .i_item_valid (item_valid),
        .o_item_pop   (item_pop),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .o_out        (out),
        .o_out_valid  (out_valid),
        .i_out_pop    (pop)
    );

    assign o_cfg_ready         = 1'b1;
    assign empty               = ~out_valid;
    assign o_mean              = out.mean;
    assign o_samples_in_window = out.fill;
    assign o_is_read_answer    = out.is_read;

endmodule

/* rtl/mma_chk.sv */
// Port-level checker for the moving average block, bound to its top level.
`include "assert_macros.svh"

module mma_chk #(
    parameter int DEPTH = mma_pkg::DEF_DEPTH
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                full,
    input logic                                empty,
    input logic                                pop,
    input logic signed [mma_pkg::MEAN_W-1:0]   o_mean,
    input logic [mma_pkg::FILL_W-1:0]          o_samples_in_window,
    input logic                                o_is_read_answer
);

    // Reset must leave no result pending and room for new requests.
    `MMA_ASSERT_ALWAYS(a_reset_empty, i_clk,
        !i_rst_n |=> (empty && !full),
        "queues not empty after reset")

    // Only read answers carry a mean.
    `MMA_ASSERT(a_mean_only_read, i_clk, i_rst_n,
        (!empty && !o_is_read_answer) |-> (o_mean == '0),
        "non-read result with nonzero mean")

    // An empty window always averages to zero.
    `MMA_ASSERT(a_empty_window, i_clk, i_rst_n,
        (!empty && (o_samples_in_window == '0)) |-> (o_mean == '0),
        "nonzero mean with empty window")

    // The fill count never passes the window depth.
    `MMA_ASSERT(a_fill_range, i_clk, i_rst_n,
        !empty |-> (32'(o_samples_in_window) <= DEPTH),
        "fill count above depth")

    // A result that is not popped stays put.
    `MMA_ASSERT(a_result_hold, i_clk, i_rst_n,
        (!empty && !pop) |=> (!empty && $stable(o_mean) && $stable(o_samples_in_window)),
        "pending result changed")

endmodule

bind multichannel_moving_average mma_chk #(.DEPTH(DEPTH)) u_mma_chk (.*);

/* dv/mma_mean_checker.sv */
// Checker for the moving average block: predicts every answer and compares it with the output.
`timescale 1ns / 100ps
module mma_mean_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    input  logic                                i_full,
    input  logic [mma_pkg::REQ_W-1:0]           i_req_type,
    input  logic [mma_pkg::CH_W-1:0]            i_channel,
    input  logic signed [mma_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                i_frame_end,
    input  logic                                i_empty,
    input  logic                                i_pop,
    input  logic signed [mma_pkg::MEAN_W-1:0]   i_mean,
    input  logic [mma_pkg::FILL_W-1:0]          i_samples_in_window,
    input  logic                                i_is_read_answer,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [mma_pkg::FILL_W-1:0]          i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending
);

    localparam int     CHANNELS = mma_pkg::DEF_CHANNELS;
    localparam int     DEPTH    = mma_pkg::DEF_DEPTH;
    localparam longint MEAN_HI  = (longint'(1) <<< (mma_pkg::MEAN_W - 1)) - 1;
    localparam longint MEAN_LO  = -(longint'(1) <<< (mma_pkg::MEAN_W - 1));

    logic signed [mma_pkg::SAMPLE_W-1:0] win_store [CHANNELS*DEPTH];
    logic signed [mma_pkg::SUM_W-1:0]    win_sums  [CHANNELS];
    int                                  frame_slot;
    int                                  fill_count;
    int                                  win_len;
    mma_pkg::t_result                    answers_due [$];

    function automatic void clear_windows();
        for (int c = 0; c < CHANNELS; c++) win_sums[c] = '0;
        frame_slot = 0;
        fill_count = 0;
    endfunction

    function automatic mma_pkg::t_result step_windows(
        input logic [mma_pkg::REQ_W-1:0]           req,
        input logic [mma_pkg::CH_W-1:0]            ch,
        input logic signed [mma_pkg::SAMPLE_W-1:0] smp,
        input logic                                fend
    );
        mma_pkg::t_result                 r;
        int                               idx;
        logic signed [mma_pkg::SUM_W-1:0] s;
        longint                           q;
        r = '0;
        case (req)
            mma_pkg::REQ_ADD: begin
                if (ch < CHANNELS && frame_slot < DEPTH) begin
                    idx = ch * DEPTH + frame_slot;
                    s = win_sums[ch];
                    // A full window drops the oldest sample of this slot first.
                    if (fill_count >= win_len) s = s - win_store[idx];
                    s = s + smp;
                    win_sums[ch] = s;
                    win_store[idx] = smp;
                    if (fend) begin
                        frame_slot = (frame_slot + 1 >= win_len) ? 0 : frame_slot + 1;
                        if (fill_count < win_len) fill_count++;
                    end
                end
            end
            mma_pkg::REQ_READ: begin
                r.is_read = 1'b1;
                if (ch < CHANNELS && fill_count != 0) begin
                    q = (longint'(win_sums[ch]) * (longint'(1) <<< mma_pkg::FRAC_W))
                        / longint'(fill_count);
                    if (q > MEAN_HI) q = MEAN_HI;
                    if (q < MEAN_LO) q = MEAN_LO;
                    r.mean = q[mma_pkg::MEAN_W-1:0];
                end
            end
            mma_pkg::REQ_CLEAR: clear_windows();
            default: ;
        endcase
        r.fill = mma_pkg::FILL_W'(fill_count);
        return r;
    endfunction

    always @(posedge i_clk) begin
        mma_pkg::t_result want;
        int               len;
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS * DEPTH; i++) win_store[i] = '0;
            win_len = (mma_pkg::WIN_RESET > DEPTH) ? DEPTH : mma_pkg::WIN_RESET;
            clear_windows();
            answers_due.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (answers_due.size() == 0) begin
                    $display("%0t: unexpected answer: mean %0d fill %0d read %0b",
                             $time, i_mean, i_samples_in_window, i_is_read_answer);
                    o_fail_count++;
                end else begin
                    want = answers_due.pop_front();
                    if (i_mean !== want.mean || i_samples_in_window !== want.fill ||
                        i_is_read_answer !== want.is_read) begin
                        $display({"%0t: answer mismatch: expected mean %0d fill %0d read %0b,",
                                  " actual mean %0d fill %0d read %0b"},
                                 $time, want.mean, want.fill, want.is_read,
                                 i_mean, i_samples_in_window, i_is_read_answer);
                        o_fail_count++;
                    end
                end
            end
            if (i_push && !i_full)
                answers_due.push_back(step_windows(i_req_type, i_channel, i_sample,
                                                   i_frame_end));
            if (i_cfg_valid && i_cfg_ready) begin
                len = i_cfg_data;
                if (len < 1) len = 1;
                if (len > DEPTH) len = DEPTH;
                win_len = len;
                // Writing the window length empties every window.
                clear_windows();
            end
        end
        o_pending = answers_due.size();
    end

endmodule

/* dv/multichannel_moving_average_tb.sv */
// Testbench top of the moving average block: clock, reset, requests, receiver and verdict.
`timescale 1ns / 100ps
module multichannel_moving_average_tb;

    localparam int                         CHANNELS     = mma_pkg::DEF_CHANNELS;
    localparam int                         DEPTH        = mma_pkg::DEF_DEPTH;
    localparam logic [mma_pkg::REQ_W-1:0]  REQ_UNUSED   = 2'd3;
    localparam int                         IDLE_LIMIT   = 2000;
    localparam int                         DRAIN_CYCLES = 40;
    localparam int                         PHASES       = 5;

    typedef enum int {RX_STEADY, RX_COIN, RX_BURSTY} t_rx_mode;

    logic                                i_clk               = 1'b0;
    logic                                i_rst_n             = 1'b0;
    logic                                push                = 1'b0;
    logic                                full;
    logic [mma_pkg::REQ_W-1:0]           i_req_type          = '0;
    logic [mma_pkg::CH_W-1:0]            i_channel           = '0;
    logic signed [mma_pkg::SAMPLE_W-1:0] i_sample            = '0;
    logic                                i_frame_end         = 1'b0;
    logic                                empty;
    logic                                pop                 = 1'b0;
    logic signed [mma_pkg::MEAN_W-1:0]   o_mean;
    logic [mma_pkg::FILL_W-1:0]          o_samples_in_window;
    logic                                o_is_read_answer;
    logic                                i_cfg_valid         = 1'b0;
    logic                                o_cfg_ready;
    logic [mma_pkg::FILL_W-1:0]          i_cfg_data          = '0;

    int       fail_count;
    int       pending;
    int       idle_cycles = 0;
    int       burst_left  = 0;
    int       slot_m      = 0;
    int       wl_m        = mma_pkg::WIN_RESET;
    bit       written [CHANNELS][DEPTH];
    int       rx_cycle    = 0;
    int       stall_left  = 0;
    t_rx_mode rx_mode     = RX_STEADY;
    int       phase_cfg    [PHASES] = '{1, 3, 0, 2, 31};
    int       phase_frames [PHASES] = '{3, 4, 1, 2, 17};

    always #10 i_clk = ~i_clk;

    multichannel_moving_average DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .push                (push),
        .full                (full),
        .i_req_type          (i_req_type),
        .i_channel           (i_channel),
        .i_sample            (i_sample),
        .i_frame_end         (i_frame_end),
        .empty               (empty),
        .pop                 (pop),
        .o_mean              (o_mean),
        .o_samples_in_window (o_samples_in_window),
        .o_is_read_answer    (o_is_read_answer),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_data          (i_cfg_data)
    );

    mma_mean_checker u_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_push              (push),
        .i_full              (full),
        .i_req_type          (i_req_type),
        .i_channel           (i_channel),
        .i_sample            (i_sample),
        .i_frame_end         (i_frame_end),
        .i_empty             (empty),
        .i_pop               (pop),
        .i_mean              (o_mean),
        .i_samples_in_window (o_samples_in_window),
        .i_is_read_answer    (o_is_read_answer),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_ready         (o_cfg_ready),
        .i_cfg_data          (i_cfg_data),
        .o_fail_count        (fail_count),
        .o_pending           (pending)
    );

    function automatic logic signed [mma_pkg::SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            default: return mma_pkg::SAMPLE_W'($urandom);
        endcase
    endfunction

    // Presents one request in bursts with random gaps and tracks which window
    // slots have been written, so that no unwritten sample is ever recalled.
    task automatic send_request(
        input logic [mma_pkg::REQ_W-1:0]           req,
        input logic [mma_pkg::CH_W-1:0]            ch,
        input logic signed [mma_pkg::SAMPLE_W-1:0] smp,
        input logic                                fend
    );
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 32);
        end
        push        <= 1'b1;
        i_req_type  <= req;
        i_channel   <= ch;
        i_sample    <= smp;
        i_frame_end <= fend;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
        burst_left--;
        if (req == mma_pkg::REQ_ADD) begin
            written[ch][slot_m] = 1'b1;
            if (fend) slot_m = (slot_m + 1 >= wl_m) ? 0 : slot_m + 1;
        end else if (req == mma_pkg::REQ_CLEAR) begin
            slot_m = 0;
        end
    endtask

    // A frame may only close once every channel holds a sample in this slot.
    task automatic add_sample(
        input logic [mma_pkg::CH_W-1:0]            ch,
        input logic signed [mma_pkg::SAMPLE_W-1:0] smp,
        input logic                                want_fend
    );
        logic ok;
        ok = want_fend;
        for (int c = 0; c < CHANNELS; c++)
            if (!written[c][slot_m] && c != ch) ok = 1'b0;
        send_request(mma_pkg::REQ_ADD, ch, smp, ok);
    endtask

    always @(negedge i_clk) begin
        if (rx_cycle % 97 == 0) rx_mode = t_rx_mode'($urandom_range(0, 2));
        rx_cycle++;
        if (stall_left > 0) begin
            stall_left--;
            pop <= 1'b0;
        end else begin
            case (rx_mode)
                RX_STEADY: pop <= 1'b1;
                RX_COIN:   pop <= 1'($urandom_range(0, 1));
                default: begin
                    pop <= 1'b1;
                    if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 20);
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("multichannel_moving_average_tb NOT OK");
                $finish;
            end
        end
    end

    initial begin
        int order [CHANNELS];
        int j;
        int t;
        int pick;
        bit early;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed requests with the reset window length of 16.
        send_request(mma_pkg::REQ_READ, 0, 16'sh1234, 1'b0);
        send_request(REQ_UNUSED, 63, -16'sd1, 1'b1);
        send_request(mma_pkg::REQ_ADD, 0, 16'sh7FFF, 1'b0);
        send_request(mma_pkg::REQ_ADD, 0, 16'sh7FFF, 1'b0);
        send_request(mma_pkg::REQ_ADD, 63, 16'sh8000, 1'b0);
        send_request(mma_pkg::REQ_ADD, 63, 16'sh8000, 1'b0);
        send_request(mma_pkg::REQ_READ, 0, -16'sd1, 1'b1);
        // Early frame end: safe here because a clear follows before the window fills.
        send_request(mma_pkg::REQ_ADD, 1, 16'sd1, 1'b1);
        send_request(mma_pkg::REQ_READ, 0, 16'sd0, 1'b0);
        send_request(mma_pkg::REQ_READ, 63, 16'sd0, 1'b0);
        send_request(mma_pkg::REQ_READ, 1, 16'sd0, 1'b0);
        send_request(mma_pkg::REQ_READ, 5, 16'sd0, 1'b0);
        send_request(mma_pkg::REQ_ADD, 1, -16'sd1, 1'b0);
        send_request(mma_pkg::REQ_READ, 1, 16'sd0, 1'b0);
        send_request(mma_pkg::REQ_ADD, 4, -16'sd5, 1'b1);
        send_request(mma_pkg::REQ_ADD, 4, -16'sd5, 1'b1);
        send_request(mma_pkg::REQ_READ, 4, 16'sd0, 1'b0);
        send_request(mma_pkg::REQ_ADD, 6, 16'sd7, 1'b0);
        send_request(mma_pkg::REQ_READ, 6, 16'sd0, 1'b0);
        send_request(mma_pkg::REQ_CLEAR, 0, 16'sh7FFF, 1'b1);
        send_request(mma_pkg::REQ_READ, 4, 16'sd0, 1'b0);
        send_request(mma_pkg::REQ_CLEAR, 63, 16'sh8000, 1'b0);

        for (int p = 0; p < PHASES; p++) begin
            // The window length is only rewritten once every answer is out.
            push <= 1'b0;
            while (pending != 0) @(negedge i_clk);
            i_cfg_valid <= 1'b1;
            i_cfg_data  <= mma_pkg::FILL_W'(phase_cfg[p]);
            do @(posedge i_clk); while (!o_cfg_ready);
            @(negedge i_clk);
            i_cfg_valid <= 1'b0;
            wl_m   = (phase_cfg[p] < 1) ? 1 : (phase_cfg[p] > DEPTH) ? DEPTH : phase_cfg[p];
            slot_m = 0;

            for (int f = 0; f < phase_frames[p]; f++) begin
                for (int i = 0; i < CHANNELS; i++) order[i] = i;
                for (int i = CHANNELS - 1; i > 0; i--) begin
                    j = $urandom_range(0, i);
                    t = order[i];
                    order[i] = order[j];
                    order[j] = t;
                end
                for (int k = 0; k < CHANNELS; k++) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 8)
                        send_request(mma_pkg::REQ_READ, mma_pkg::CH_W'($urandom),
                                     mma_pkg::SAMPLE_W'($urandom), 1'($urandom_range(0, 1)));
                    else if (pick == 8)
                        send_request(REQ_UNUSED, mma_pkg::CH_W'($urandom),
                                     mma_pkg::SAMPLE_W'($urandom), 1'($urandom_range(0, 1)));
                    else if (pick == 9)
                        add_sample(mma_pkg::CH_W'($urandom), rand_sample(), 1'b0);
                    else if (pick == 10 && wl_m < 8)
                        send_request(mma_pkg::REQ_CLEAR, mma_pkg::CH_W'($urandom),
                                     mma_pkg::SAMPLE_W'($urandom), 1'($urandom_range(0, 1)));
                    early = (k < CHANNELS - 1) && ($urandom_range(0, 39) == 0);
                    add_sample(mma_pkg::CH_W'(order[k]), rand_sample(),
                               (k == CHANNELS - 1) || early);
                end
            end
        end

        push <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("multichannel_moving_average_tb OK");
        end else begin
            $display("multichannel_moving_average_tb NOT OK");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/mma_pkg.sv
rtl/mma_ram.sv
rtl/mma_front.sv
rtl/mma_div.sv
rtl/mma_back.sv
rtl/multichannel_moving_average.sv
rtl/mma_chk.sv
dv/mma_mean_checker.sv
dv/multichannel_moving_average_tb.sv
